// File: rtl/vle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vle_pkg;

    typedef enum logic [3:0] {
        CMD_ADD_FIRST    = 4'd0,
        CMD_ADD_LAST     = 4'd1,
        CMD_ADD_AT       = 4'd2,
        CMD_ADD_SORTED   = 4'd3,
        CMD_REMOVE_MATCH = 4'd4,
        CMD_REMOVE_ALL   = 4'd5,
        CMD_REMOVE_AT    = 4'd6,
        CMD_CLEAR        = 4'd7,
        CMD_READ_AT      = 4'd8,
        CMD_REVERSE      = 4'd9,
        CMD_SORT         = 4'd10,
        CMD_MAX_INDEX    = 4'd11
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [5:0]         found_index;
        logic [6:0]         removed_count;
        logic [6:0]         entry_count;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
    } t_rsp;

endpackage
`default_nettype wire

// File: rtl/vle_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vle_req_if;
    logic          valid;
    logic          ready;
    vle_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vle_rsp_if;
    logic          valid;
    logic          ready;
    vle_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/vle_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module vle_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/value_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// value_list_engine: ordered list of up to CAPACITY signed 32-bit values.
// Channels: i_req (command, value, position) and o_rsp (status, read value,
// found index, removed count, entry count, first and last values), both
// valid/ready; a transfer happens when valid and ready are both high.
// Values live in one single-port-write, registered-read RAM; a sequencer
// walks it one entry per step, each step being an address cycle, a RAM
// cycle and a data cycle. Sort is an insertion sort. Head and tail
// values are fetched at the end of every command. One command is in
// flight at a time; the next is taken in the cycle after the result
// transfer.
// Reset empties the list at once (no clearing pass); the RAM is not reset.
// While the receiver stalls, the result is held in the output register and
// no new command is taken until it has been transferred.
module value_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vle_req_if.sink    i_req,
    vle_rsp_if.source  o_rsp
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_WAIT,
        S_SRCH_RD, S_SRCH_CHK,         // add_sorted / remove_first search
        S_SHR_RD, S_SHR_WR,            // shift up for insert
        S_SHL_RD, S_SHL_WR,            // shift down for delete
        S_RALL_RD, S_RALL_WR,          // compaction
        S_READ_RD, S_READ_WR,
        S_REV_RDA, S_REV_RDB, S_REV_WRA, S_REV_WRB,
        S_MAX_RD, S_MAX_CHK,
        S_SRT_RDT, S_SRT_GETT, S_SRT_RDP, S_SRT_CHK, S_SRT_PUT,
        S_HD_RD, S_HD_GET, S_TL_GET, S_OUT
    } t_state;

    t_state              r_state;
    t_state              r_ret;
    vle_pkg::t_req       r_req;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_i, r_j, r_k;
    logic [31:0]         r_t;
    logic [1:0]          r_status;
    logic [31:0]         r_rd;
    logic [AW-1:0]       r_found;
    logic [CW-1:0]       r_removed;
    logic [31:0]         r_first;
    logic                r_we;
    logic [AW-1:0]       r_waddr, r_raddr;
    logic [31:0]         r_wdata;
    logic                r_ins;
    logic [31:0]         w_rdata;
    vle_pkg::t_rsp       r_rsp;
    logic                r_ovalid;

    vle_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic logic [AW-1:0] ad(input logic [CW-1:0] x);
        logic [CW+AW-1:0] e;
        e = {{AW{1'b0}}, x};
        return e[AW-1:0];
    endfunction

    logic full;
    assign full = (r_count >= CW'(CAPACITY));

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.data   = r_rsp;

    // command sequencer
    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req     <= i_req.data;
                        r_status  <= vle_pkg::ST_OK;
                        r_rd      <= '0;
                        r_found   <= '0;
                        r_removed <= '0;
                        r_state   <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_state <= S_HD_RD;
                    r_i     <= '0;
                    r_t     <= r_req.value;
                    case (r_req.command)
                        vle_pkg::CMD_ADD_FIRST: begin
                            if (full) r_status <= vle_pkg::ST_FULL;
                            else begin r_k <= '0; r_j <= r_count; r_state <= S_SHR_RD; end
                        end
                        vle_pkg::CMD_ADD_LAST: begin
                            if (full) r_status <= vle_pkg::ST_FULL;
                            else begin r_k <= r_count; r_j <= r_count; r_state <= S_SHR_RD; end
                        end
                        vle_pkg::CMD_ADD_AT: begin
                            if ({1'b0, r_req.position} > (8)'(r_count))
                                r_status <= vle_pkg::ST_RANGE;
                            else if (full) r_status <= vle_pkg::ST_FULL;
                            else begin
                                r_k <= CW'(r_req.position); r_j <= r_count;
                                r_state <= S_SHR_RD;
                            end
                        end
                        vle_pkg::CMD_ADD_SORTED: begin
                            if (full) r_status <= vle_pkg::ST_FULL;
                            else begin r_ins <= 1'b1; r_state <= S_SRCH_RD; end
                        end
                        vle_pkg::CMD_REMOVE_MATCH: begin
                            r_ins <= 1'b0; r_state <= S_SRCH_RD;
                        end
                        vle_pkg::CMD_REMOVE_ALL: begin
                            r_j <= '0; r_state <= S_RALL_RD;
                        end
                        vle_pkg::CMD_REMOVE_AT: begin
                            if ({1'b0, r_req.position} >= (8)'(r_count))
                                r_status <= vle_pkg::ST_RANGE;
                            else begin
                                r_removed <= CW'(1);
                                r_i <= CW'(r_req.position);
                                r_state <= S_SHL_RD;
                            end
                        end
                        vle_pkg::CMD_CLEAR: begin
                            r_removed <= r_count;
                            r_count   <= '0;
                        end
                        vle_pkg::CMD_READ_AT: begin
                            if (r_count == '0) r_status <= vle_pkg::ST_EMPTY;
                            else if ({1'b0, r_req.position} >= (8)'(r_count))
                                r_status <= vle_pkg::ST_RANGE;
                            else begin
                                r_raddr <= ad(CW'(r_req.position));
                                r_state <= S_READ_RD;
                            end
                        end
                        vle_pkg::CMD_REVERSE: begin
                            if (r_count == '0) r_status <= vle_pkg::ST_EMPTY;
                            else begin r_j <= r_count - CW'(1); r_state <= S_REV_RDA; end
                        end
                        vle_pkg::CMD_SORT: begin
                            r_i <= CW'(1); r_state <= S_SRT_RDT;
                        end
                        vle_pkg::CMD_MAX_INDEX: begin
                            if (r_count == '0) r_status <= vle_pkg::ST_EMPTY;
                            else begin
                                r_raddr <= '0; r_state <= S_MAX_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                // RAM cycle: address registered, data arrives next cycle
                S_WAIT: r_state <= r_ret;
                // linear search: first greater (insert) or first equal (remove)
                S_SRCH_RD: begin
                    if (r_i >= r_count) begin
                        if (r_ins) begin
                            r_k <= r_count; r_j <= r_count; r_state <= S_SHR_RD;
                        end else r_state <= S_HD_RD;
                    end else begin
                        r_raddr <= ad(r_i); r_ret <= S_SRCH_CHK; r_state <= S_WAIT;
                    end
                end
                S_SRCH_CHK: begin
                    if (r_ins ? sgt(w_rdata, r_t) : (w_rdata == r_t)) begin
                        if (r_ins) begin
                            r_k <= r_i; r_j <= r_count; r_state <= S_SHR_RD;
                        end else begin
                            r_removed <= CW'(1); r_state <= S_SHL_RD;
                        end
                    end else begin
                        r_i <= r_i + CW'(1); r_state <= S_SRCH_RD;
                    end
                end
                // shift entries k..count-1 up by one, then place value at k
                S_SHR_RD: begin
                    if (r_j > r_k) begin
                        r_raddr <= ad(r_j - CW'(1)); r_ret <= S_SHR_WR; r_state <= S_WAIT;
                    end else begin
                        r_we <= 1'b1; r_waddr <= ad(r_k); r_wdata <= r_t;
                        r_count <= r_count + CW'(1);
                        r_state <= S_HD_RD;
                    end
                end
                S_SHR_WR: begin
                    r_we <= 1'b1; r_waddr <= ad(r_j); r_wdata <= w_rdata;
                    r_j <= r_j - CW'(1); r_state <= S_SHR_RD;
                end
                // shift entries after i down by one
                S_SHL_RD: begin
                    if (r_i + CW'(1) < r_count) begin
                        r_raddr <= ad(r_i + CW'(1)); r_ret <= S_SHL_WR; r_state <= S_WAIT;
                    end else begin
                        r_count <= r_count - CW'(1); r_state <= S_HD_RD;
                    end
                end
                S_SHL_WR: begin
                    r_we <= 1'b1; r_waddr <= ad(r_i); r_wdata <= w_rdata;
                    r_i <= r_i + CW'(1); r_state <= S_SHL_RD;
                end
                // compaction: i reads, j writes
                S_RALL_RD: begin
                    if (r_i >= r_count) begin
                        r_count <= r_j; r_state <= S_HD_RD;
                    end else begin
                        r_raddr <= ad(r_i); r_ret <= S_RALL_WR; r_state <= S_WAIT;
                    end
                end
                S_RALL_WR: begin
                    if (w_rdata == r_t) r_removed <= r_removed + CW'(1);
                    else begin
                        r_we <= 1'b1; r_waddr <= ad(r_j); r_wdata <= w_rdata;
                        r_j <= r_j + CW'(1);
                    end
                    r_i <= r_i + CW'(1); r_state <= S_RALL_RD;
                end
                S_READ_RD: r_state <= S_READ_WR;
                S_READ_WR: begin
                    r_rd <= w_rdata; r_state <= S_HD_RD;
                end
                // reverse: swap i and j pairwise
                S_REV_RDA: begin
                    if (r_i < r_j) begin
                        r_raddr <= ad(r_i); r_state <= S_REV_RDB;
                    end else r_state <= S_HD_RD;
                end
                S_REV_RDB: begin
                    r_raddr <= ad(r_j); r_state <= S_REV_WRA;
                end
                S_REV_WRA: begin
                    r_t <= w_rdata; r_state <= S_REV_WRB;
                end
                S_REV_WRB: begin
                    r_we <= 1'b1; r_waddr <= ad(r_i); r_wdata <= w_rdata;
                    r_first <= r_t; r_k <= r_j;
                    r_state <= S_SRT_PUT;
                end
                // max scan: r_t holds current maximum
                S_MAX_RD: begin
                    if (r_i >= r_count) r_state <= S_HD_RD;
                    else begin
                        r_raddr <= ad(r_i); r_ret <= S_MAX_CHK; r_state <= S_WAIT;
                    end
                end
                S_MAX_CHK: begin
                    if (r_i == '0 || sgt(w_rdata, r_t)) begin
                        r_t <= w_rdata; r_found <= ad(r_i);
                    end
                    r_i <= r_i + CW'(1); r_state <= S_MAX_RD;
                end
                // insertion sort: key in r_t, hole at r_j
                S_SRT_RDT: begin
                    if (r_i >= r_count) r_state <= S_HD_RD;
                    else begin
                        r_raddr <= ad(r_i); r_ret <= S_SRT_GETT; r_state <= S_WAIT;
                    end
                end
                S_SRT_GETT: begin
                    r_t <= w_rdata; r_j <= r_i; r_state <= S_SRT_RDP;
                end
                S_SRT_RDP: begin
                    if (r_j == '0) begin
                        r_we <= 1'b1; r_waddr <= '0; r_wdata <= r_t;
                        r_i <= r_i + CW'(1); r_state <= S_SRT_RDT;
                    end else begin
                        r_raddr <= ad(r_j - CW'(1)); r_ret <= S_SRT_CHK; r_state <= S_WAIT;
                    end
                end
                S_SRT_CHK: begin
                    r_we <= 1'b1; r_waddr <= ad(r_j);
                    if (sgt(w_rdata, r_t)) begin
                        r_wdata <= w_rdata; r_j <= r_j - CW'(1); r_state <= S_SRT_RDP;
                    end else begin
                        r_wdata <= r_t; r_i <= r_i + CW'(1); r_state <= S_SRT_RDT;
                    end
                end
                // second write of a reverse swap
                S_SRT_PUT: begin
                    r_we <= 1'b1; r_waddr <= ad(r_k); r_wdata <= r_first;
                    r_i <= r_i + CW'(1); r_j <= r_j - CW'(1);
                    r_state <= S_REV_RDA;
                end
                // fetch head and tail for the result
                S_HD_RD: begin
                    r_raddr <= '0; r_state <= S_HD_GET;
                end
                S_HD_GET: begin
                    r_raddr <= ad(r_count - CW'(1)); r_state <= S_TL_GET;
                end
                S_TL_GET: begin
                    r_first <= w_rdata; r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid              <= 1'b1;
                        r_rsp.status          <= r_status;
                        r_rsp.read_value      <= r_rd;
                        r_rsp.found_index     <= 6'(r_found);
                        r_rsp.removed_count   <= 7'(r_removed);
                        r_rsp.entry_count     <= 7'(r_count);
                        r_rsp.first_value     <= (r_count != '0) ? r_first : '0;
                        r_rsp.last_value      <= (r_count != '0) ? w_rdata : '0;
                    end else if (o_rsp.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count above capacity");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !i_req.ready) else $error("accepting while result pending");
    a_ovalid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_OUT) else $error("result valid outside output");
endmodule
`default_nettype wire
